FILE: rtl/lz78be_pkg.sv
// ----------------------------------------------------------------------------
// LZ78 bitwise encoder package
// Shared sizes and request types for the bitwise LZ78 encoder core.
// ----------------------------------------------------------------------------
package lz78be_pkg;

    // Number of phrase nodes in the trie, the root included.
    localparam int DICT_ENTRIES = 4096;

    // Width of a node index, and of the phrase counter that can hold DICT_ENTRIES.
    localparam int IDX_W   = $clog2(DICT_ENTRIES);
    localparam int NP_W    = IDX_W + 1;

    // One trie entry holds the child for bit 0 (low half) and for bit 1 (high half).
    localparam int ENTRY_W = 2 * IDX_W;

    // Counter wide enough for a full pair: index bits plus the branch bit.
    localparam int CNT_W   = $clog2(IDX_W + 2);

    // Input request: one source byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    // Output request: one packed code byte.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_stream;
    } t_out;

endpackage

FILE: rtl/lz78_bitwise_encoder_core.sv
// ----------------------------------------------------------------------------
// LZ78 bitwise encoder core
// Walks a binary phrase trie bit by bit and emits packed (index, bit) pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid, o_stall, i_data): one source byte per request, read
//   most significant bit first. last_byte marks the final byte of a stream.
//   Output channel (o_valid, i_stall, o_data): packed code bytes, code bits
//   filled from bit 0 up (after reset the first byte starts at bit 2).
//   last_of_run flags the final byte caused by one input request, and
//   end_of_stream flags the final byte of the compressed stream, zero-padded
//   when only partly filled. Each input bit takes a trie lookup (memory read,
//   then decide), and each pair of up to 12 index bits plus the branch bit is
//   shifted out one code bit per cycle while the output can take a full byte.
//   A request closes with an end-of-byte check, then the release of the held
//   byte and, for a final request, the flush byte; no new byte is taken until
//   the core is back in idle. The trie lookup and one-bit shifter set the pace.
//   After reset the trie memory is swept clear, one entry a cycle, over all
//   DICT_ENTRIES (4096) entries; o_stall stays high until that is done.
//   Every stream needs its own reset. When the receiver stalls with a byte
//   still held and another byte completes, the bit shifter waits.
// ----------------------------------------------------------------------------
module lz78_bitwise_encoder_core
    import lz78be_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_LOOK  = 7'b0001000,
        S_EMIT  = 7'b0010000,
        S_ENDB  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // Control registers.
    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    logic [IDX_W-1:0]   r_clr, n_clr;
    logic [NP_W-1:0]    r_np, n_np;
    logic [CNT_W-1:0]   r_width, n_width;
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic [IDX_W-1:0]   r_parent, n_parent;
    logic [7:0]         r_pbits, n_pbits;
    logic [2:0]         r_pcnt, n_pcnt;
    logic               r_lastbit, n_lastbit;
    logic               r_hold_v, n_hold_v;
    logic               r_ov, n_ov;
    logic [2:0]         r_bcnt, n_bcnt;
    logic [CNT_W-1:0]   r_scnt, n_scnt;

    // Payload registers.
    logic [7:0]         r_data, n_data;
    logic               r_last, n_last;
    logic [IDX_W-1:0]   r_pair, n_pair;
    logic               r_pbit, n_pbit;
    logic [7:0]         r_hold, n_hold;
    t_out               r_out, n_out;

    // Trie memory.
    logic [ENTRY_W-1:0] r_mem [DICT_ENTRIES];
    logic [ENTRY_W-1:0] r_rdata;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [ENTRY_W-1:0] mem_wd;

    logic               out_free;
    logic               e_bit;
    logic               cur_bit;
    logic [IDX_W-1:0]   child;
    logic               byte_done;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // The output register can take a new byte when empty or being drained.
    assign out_free = !r_ov || !i_stall;

    // Next code bit: index bits LSB first, then the branch bit.
    assign e_bit     = (r_scnt == CNT_W'(1)) ? r_pbit : r_pair[0];
    assign cur_bit   = r_data[7];
    assign child     = cur_bit ? r_rdata[ENTRY_W-1:IDX_W] : r_rdata[IDX_W-1:0];
    assign byte_done = (r_pcnt == 3'd7);

    // Next-state and datapath logic.
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_clr     = r_clr;
        n_np      = r_np;
        n_width   = r_width;
        n_cur     = r_cur;
        n_parent  = r_parent;
        n_pbits   = r_pbits;
        n_pcnt    = r_pcnt;
        n_lastbit = r_lastbit;
        n_hold_v  = r_hold_v;
        n_bcnt    = r_bcnt;
        n_scnt    = r_scnt;
        n_data    = r_data;
        n_last    = r_last;
        n_pair    = r_pair;
        n_pbit    = r_pbit;
        n_hold    = r_hold;
        n_out     = r_out;
        n_ov      = r_ov && i_stall;
        mem_we    = 1'b0;
        mem_wa    = r_cur;
        mem_wd    = '0;

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                n_clr  = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(DICT_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_valid) begin
                    n_data  = i_data.data_byte;
                    n_last  = i_data.last_byte;
                    n_bcnt  = 3'd7;
                    n_state = S_READ;
                end
            end

            // The memory read of the current node is issued here.
            S_READ: begin
                n_state = S_LOOK;
            end

            // Follow the child, or emit a pair and, while the dictionary has room, grow the trie.
            S_LOOK: begin
                n_lastbit = cur_bit;
                n_data    = {r_data[6:0], 1'b0};
                n_bcnt    = r_bcnt - 3'd1;
                if (child != '0) begin
                    n_parent = r_cur;
                    n_cur    = child;
                    n_state  = (r_bcnt != 3'd0) ? S_READ : S_ENDB;
                end else begin
                    n_pair = r_cur;
                    n_pbit = cur_bit;
                    n_scnt = r_width + CNT_W'(1);
                    if (r_np < NP_W'(DICT_ENTRIES)) begin
                        mem_we = 1'b1;
                        if (cur_bit) begin
                            mem_wd = {r_np[IDX_W-1:0], r_rdata[IDX_W-1:0]};
                        end else begin
                            mem_wd = {r_rdata[ENTRY_W-1:IDX_W], r_np[IDX_W-1:0]};
                        end
                        n_np = r_np + NP_W'(1);
                        // The code width grows once the phrase count passes a power of two.
                        if (r_np >= NP_W'(2) && (r_np & (r_np - NP_W'(1))) == '0) begin
                            n_width = r_width + CNT_W'(1);
                        end
                    end
                    n_cur    = '0;
                    n_parent = '0;
                    n_ret    = (r_bcnt != 3'd0) ? S_READ : S_ENDB;
                    n_state  = S_EMIT;
                end
            end

            // Shift one code bit a cycle into the pending byte; a held byte can stall it.
            S_EMIT: begin
                if (!byte_done || !r_hold_v || out_free) begin
                    if (byte_done) begin
                        if (r_hold_v) begin
                            n_ov  = 1'b1;
                            n_out = '{out_byte: r_hold, last_of_run: 1'b0,
                                      end_of_stream: 1'b0};
                        end
                        n_hold   = r_pbits | {e_bit, 7'd0};
                        n_hold_v = 1'b1;
                        n_pbits  = '0;
                        n_pcnt   = '0;
                    end else begin
                        n_pbits = r_pbits | (8'(e_bit) << r_pcnt);
                        n_pcnt  = r_pcnt + 3'd1;
                    end
                    n_pair = r_pair >> 1;
                    n_scnt = r_scnt - CNT_W'(1);
                    if (r_scnt == CNT_W'(1)) begin
                        n_state = r_ret;
                    end
                end
            end

            // End of the byte: a final byte inside the trie sends its leftover phrase.
            S_ENDB: begin
                if (r_last && r_cur != '0) begin
                    n_pair  = r_parent;
                    n_pbit  = r_lastbit;
                    n_scnt  = r_width + CNT_W'(1);
                    n_ret   = S_DONE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DONE;
                end
            end

            // Release the held byte and, on the final byte, the padded flush byte.
            S_DONE: begin
                if (out_free) begin
                    if (r_hold_v) begin
                        n_ov     = 1'b1;
                        n_hold_v = 1'b0;
                        if (r_last && r_pcnt != 3'd0) begin
                            n_out = '{out_byte: r_hold, last_of_run: 1'b0,
                                      end_of_stream: 1'b0};
                        end else begin
                            n_out   = '{out_byte: r_hold, last_of_run: 1'b1,
                                        end_of_stream: r_last};
                            n_state = S_IDLE;
                        end
                    end else begin
                        if (r_last) begin
                            n_ov  = 1'b1;
                            n_out = '{out_byte: r_pbits, last_of_run: 1'b1,
                                      end_of_stream: 1'b1};
                        end
                        n_state = S_IDLE;
                    end
                    // A finished stream restarts the walk with nothing pending.
                    if (r_last && n_state == S_IDLE) begin
                        n_pbits  = '0;
                        n_pcnt   = '0;
                        n_cur    = '0;
                        n_parent = '0;
                    end
                end
            end

            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_ret     <= S_READ;
            r_clr     <= '0;
            r_np      <= NP_W'(1);
            r_width   <= CNT_W'(1);
            r_cur     <= '0;
            r_parent  <= '0;
            r_pbits   <= '0;
            r_pcnt    <= 3'd2;
            r_lastbit <= 1'b0;
            r_hold_v  <= 1'b0;
            r_ov      <= 1'b0;
            r_bcnt    <= '0;
            r_scnt    <= '0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_clr     <= n_clr;
            r_np      <= n_np;
            r_width   <= n_width;
            r_cur     <= n_cur;
            r_parent  <= n_parent;
            r_pbits   <= n_pbits;
            r_pcnt    <= n_pcnt;
            r_lastbit <= n_lastbit;
            r_hold_v  <= n_hold_v;
            r_ov      <= n_ov;
            r_bcnt    <= n_bcnt;
            r_scnt    <= n_scnt;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_last <= n_last;
        r_pair <= n_pair;
        r_pbit <= n_pbit;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    // Trie memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (r_state == S_READ) begin
            r_rdata <= r_mem[r_cur];
        end
    end

`ifndef ASSERT_OFF
    // The stream end is always the last byte of its request.
    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_data.end_of_stream || o_data.last_of_run))
        else $error("end_of_stream without last_of_run");

    // No code byte is left behind when a request is finished.
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("held byte left over in idle");

    // The phrase counter stops at the dictionary size.
    a_np_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_np <= NP_W'(DICT_ENTRIES))
        else $error("phrase counter past dictionary size");

    // A pair being shifted out always has bits left.
    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_scnt != '0 && r_scnt <= r_width + CNT_W'(1)))
        else $error("bad pair bit count");
`endif

endmodule
